FILE: rtl/core/idea_pkg.sv
// Shared types, constants and mod-65537 arithmetic for the IDEA cipher engine.
package idea_pkg;

    localparam int ROUNDS      = 8;
    localparam int NUM_SUBKEYS = 6 * ROUNDS + 4;
    localparam int NUM_STAGES  = 6 * ROUNDS + 2;
    localparam int KEY_ROT     = 25;
    localparam int CFG_IDX_W   = 2;
    localparam int SK_IDX_W    = $clog2(NUM_SUBKEYS);

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_UPPER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOWER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd2;

    typedef logic [15:0] t_word;
    typedef logic [32:0] t_prod;
    typedef logic [NUM_SUBKEYS-1:0][15:0] t_fwd;

    // working set carried by one pipeline stage
    typedef struct packed {
        t_word x1;
        t_word x2;
        t_word x3;
        t_word x4;
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
        t_prod p1;
        t_prod p2;
    } t_stg;

    // full product of two words, 0 read as 65536
    function automatic t_prod mm_mul(input t_word a, input t_word b);
        logic [16:0] x;
        logic [16:0] y;
        logic [33:0] p;
        x = (a == 16'd0) ? 17'h10000 : {1'b0, a};
        y = (b == 16'd0) ? 17'h10000 : {1'b0, b};
        p = x * y;
        return p[32:0];
    endfunction

    // p mod 65537 via 65536 == -1; 65536 folds back to 0
    function automatic t_word mm_red(input t_prod p);
        logic [17:0] dif;
        dif = {2'b00, p[15:0]} - {1'b0, p[32:16]};
        if (dif[17]) begin
            dif = dif + 18'd65537;
        end
        return dif[15:0];
    endfunction

    // forward schedule: eight words per 25-bit left rotation of the key
    function automatic t_fwd fwd_sched(input logic [127:0] key);
        t_fwd f;
        logic [127:0] rk;
        f  = '0;
        rk = key;
        for (int g = 0; g < (NUM_SUBKEYS + 7) / 8; g++) begin
            for (int w = 0; w < 8; w++) begin
                if (g * 8 + w < NUM_SUBKEYS) begin
                    f[g * 8 + w] = rk[127 - 16 * w -: 16];
                end
            end
            rk = {rk[127-KEY_ROT:0], rk[127:128-KEY_ROT]};
        end
        return f;
    endfunction

endpackage

FILE: rtl/core/idea_if.sv
// Handshake channel interfaces: input block, result block, configuration write.
interface idea_in_if
    import idea_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [63:0] data_block;
    modport src (output valid, output data_block, input ready);
    modport snk (input valid, input data_block, output ready);
endinterface

interface idea_out_if
    import idea_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [63:0] result_block;
    modport src (output valid, output result_block, input ready);
    modport snk (input valid, input result_block, output ready);
endinterface

interface idea_cfg_if
    import idea_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;
    modport src (output valid, output index, output data, input ready);
    modport snk (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/idea_block_cipher.sv
// IDEA cipher engine: subkey builder and fully pipelined rounds.
//
//  channel   dir  payload                  accepted when
//  i_blk     in   data_block [63:0]        valid & ready
//  o_res     out  result_block [63:0]      valid & ready
//  i_cfg     in   index [1:0], data [63:0] valid & ready
//
//  One item per cycle while the skid register is empty and no subkey rebuild runs;
//  six stages per round, two for the output transform, one output register.
//  A key or mode write rebuilds the 52 subkeys in one pass: a plain subkey is
//  written directly, an inverted one takes 16 square-and-multiply steps; only
//  decrypt mode inverts subkeys. Input ready is low meanwhile.
//  Reset is synchronous, active low, and clears control, key and mode only; the subkeys are
//  undefined until the first configuration write.
//  A stalled output parks one result in a skid register; the pipeline halts
//  only once that is full.
module idea_block_cipher
    import idea_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    idea_in_if.snk   i_blk,
    idea_out_if.src  o_res,
    idea_cfg_if.snk  i_cfg
);

    typedef enum logic [1:0] {S_IDLE, S_PICK, S_MUL, S_RED} t_bstate;
    typedef enum logic [1:0] {K_PLAIN, K_NEG, K_INV} t_kind;

    // ---------------- configuration and subkey builder ----------------
    t_bstate      r_st;
    logic [63:0]  r_key_hi;
    logic [63:0]  r_key_lo;
    logic         r_dec;
    logic [SK_IDX_W-1:0] r_k;
    logic [3:0]   r_r;
    logic [2:0]   r_j;
    logic [3:0]   r_cnt;
    t_word        r_res;
    t_word        r_base;
    t_prod        r_pa;
    t_prod        r_pb;
    t_word        r_subkey [NUM_SUBKEYS];

    t_fwd         w_fwd;
    logic [6:0]   w_b;
    logic [6:0]   w_src;
    logic         w_swap;
    t_kind        w_kind;
    t_word        w_fw;
    logic         cfg_acc;
    logic         cfg_hit;

    assign w_fwd   = fwd_sched({r_key_hi, r_key_lo});
    assign cfg_acc = i_cfg.valid && i_cfg.ready;
    assign cfg_hit = (i_cfg.index == CFG_KEY_UPPER) || (i_cfg.index == CFG_KEY_LOWER)
                     || (i_cfg.index == CFG_DECRYPT_MODE);
    assign i_cfg.ready = (r_st == S_IDLE);

    always_comb begin
        w_b    = 7'(6 * ROUNDS) - 7'(r_r) * 7'd6;
        w_swap = (r_r != 4'd0) && (r_r != 4'(ROUNDS));
        w_src  = {1'b0, r_k};
        w_kind = K_PLAIN;
        if (r_dec) begin
            case (r_j)
                3'd0: begin w_src = w_b;                       w_kind = K_INV; end
                3'd1: begin w_src = w_b + (w_swap ? 7'd2 : 7'd1); w_kind = K_NEG; end
                3'd2: begin w_src = w_b + (w_swap ? 7'd1 : 7'd2); w_kind = K_NEG; end
                3'd3: begin w_src = w_b + 7'd3;                w_kind = K_INV; end
                3'd4: begin w_src = w_b - 7'd2;                w_kind = K_PLAIN; end
                default: begin w_src = w_b - 7'd1;             w_kind = K_PLAIN; end
            endcase
        end
        w_fw = w_fwd[w_src[SK_IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_dec    <= 1'b0;
            r_k      <= '0;
            r_r      <= '0;
            r_j      <= '0;
            r_cnt    <= '0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (cfg_acc && cfg_hit) begin
                        if (i_cfg.index == CFG_KEY_UPPER) begin
                            r_key_hi <= i_cfg.data;
                        end else if (i_cfg.index == CFG_KEY_LOWER) begin
                            r_key_lo <= i_cfg.data;
                        end else begin
                            r_dec <= i_cfg.data[0];
                        end
                        r_k  <= '0;
                        r_r  <= '0;
                        r_j  <= '0;
                        r_st <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (w_kind == K_INV) begin
                        r_base <= w_fw;
                        r_res  <= 16'd1;
                        r_cnt  <= '0;
                        r_st   <= S_MUL;
                    end else begin
                        r_subkey[r_k] <= (w_kind == K_NEG) ? (16'd0 - w_fw) : w_fw;
                        if (r_k == SK_IDX_W'(NUM_SUBKEYS - 1)) begin
                            r_st <= S_IDLE;
                        end
                        r_k <= r_k + 1'b1;
                        r_j <= (r_j == 3'd5) ? 3'd0 : r_j + 3'd1;
                        r_r <= (r_j == 3'd5) ? r_r + 4'd1 : r_r;
                    end
                end
                S_MUL: begin
                    r_pa <= mm_mul(r_res, r_base);
                    r_pb <= mm_mul(r_base, r_base);
                    r_st <= S_RED;
                end
                S_RED: begin
                    // exponent 65535: every bit set, multiply at every step
                    r_res  <= mm_red(r_pa);
                    r_base <= mm_red(r_pb);
                    r_cnt  <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_subkey[r_k] <= mm_red(r_pa);
                        if (r_k == SK_IDX_W'(NUM_SUBKEYS - 1)) begin
                            r_st <= S_IDLE;
                        end else begin
                            r_st <= S_PICK;
                        end
                        r_k <= r_k + 1'b1;
                        r_j <= (r_j == 3'd5) ? 3'd0 : r_j + 3'd1;
                        r_r <= (r_j == 3'd5) ? r_r + 4'd1 : r_r;
                    end else begin
                        r_st <= S_MUL;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // ---------------- round pipeline ----------------
    logic                 en;
    logic                 in_acc;
    logic [NUM_STAGES-1:0] r_v;
    t_stg                 r_s   [NUM_STAGES];
    t_stg                 n_s   [NUM_STAGES];
    t_stg                 w_prv [NUM_STAGES];
    t_stg                 s_in;

    logic         r_out_v;
    logic         r_skid_v;
    logic [63:0]  r_out;
    logic [63:0]  r_skid;
    logic [63:0]  w_y;
    logic         take;

    assign en     = !r_skid_v;
    assign i_blk.ready = en && (r_st == S_IDLE);
    assign in_acc = i_blk.valid && i_blk.ready;

    always_comb begin
        s_in    = '0;
        s_in.x1 = i_blk.data_block[63:48];
        s_in.x2 = i_blk.data_block[47:32];
        s_in.x3 = i_blk.data_block[31:16];
        s_in.x4 = i_blk.data_block[15:0];
    end

    assign w_prv[0] = s_in;

    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stg
        localparam int RND = i / 6;
        localparam int PH  = i % 6;
        localparam int ZB  = 6 * RND;

        if (i > 0) begin : g_lnk
            assign w_prv[i] = r_s[i-1];
        end

        if (RND == ROUNDS) begin : g_out
            // output transform; middle words cross back
            always_comb begin
                t_stg s;
                s = w_prv[i];
                if (PH == 0) begin
                    s.p1 = mm_mul(s.x1, r_subkey[ZB]);
                    s.p2 = mm_mul(s.x4, r_subkey[ZB + 3]);
                    s.b  = s.x3 + r_subkey[ZB + 1];
                    s.c  = s.x2 + r_subkey[ZB + 2];
                end else begin
                    s.x1 = mm_red(s.p1);
                    s.x2 = s.b;
                    s.x3 = s.c;
                    s.x4 = mm_red(s.p2);
                end
                n_s[i] = s;
            end
        end else begin : g_rnd
            always_comb begin
                t_stg  s;
                t_word g;
                t_word h;
                s = w_prv[i];
                g = '0;
                h = '0;
                case (PH)
                    0: begin
                        s.p1 = mm_mul(s.x1, r_subkey[ZB]);
                        s.p2 = mm_mul(s.x4, r_subkey[ZB + 3]);
                        s.b  = s.x2 + r_subkey[ZB + 1];
                        s.c  = s.x3 + r_subkey[ZB + 2];
                    end
                    1: begin
                        s.a = mm_red(s.p1);
                        s.d = mm_red(s.p2);
                    end
                    2: s.p1 = mm_mul(s.a ^ s.c, r_subkey[ZB + 4]);
                    3: begin
                        s.e  = mm_red(s.p1);
                        s.x2 = (s.b ^ s.d) + mm_red(s.p1);
                    end
                    4: s.p1 = mm_mul(s.x2, r_subkey[ZB + 5]);
                    default: begin
                        g    = mm_red(s.p1);
                        h    = s.e + g;
                        s.x1 = s.a ^ g;
                        s.x2 = s.c ^ g;
                        s.x3 = s.b ^ h;
                        s.x4 = s.d ^ h;
                    end
                endcase
                n_s[i] = s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NUM_STAGES-2:0], in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s <= n_s;
        end
    end

    // ---------------- output register and skid ----------------
    assign w_y  = {r_s[NUM_STAGES-1].x1, r_s[NUM_STAGES-1].x2,
                   r_s[NUM_STAGES-1].x3, r_s[NUM_STAGES-1].x4};
    assign take = r_out_v && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (r_v[NUM_STAGES-1]) begin
            if (!r_out_v || take) begin
                r_out   <= w_y;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= w_y;
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_res.valid        = r_out_v;
    assign o_res.result_block = r_out;

    // ---------------- checks ----------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds an item while output is empty");

    a_cfg_starts_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_acc && cfg_hit) |=> (r_st == S_PICK))
        else $error("config write did not start subkey rebuild");

    a_no_entry_while_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_st != S_IDLE) && en) |=> !r_v[0])
        else $error("item entered pipeline during subkey rebuild");

endmodule
